@@ src/pcss_pkg.sv @@
// Shared types and constants for the periodic callback slot scheduler.
// Used by the top level and by its port checker; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package pcss_pkg;

  // Default number of timer slots in the table
  localparam int SLOTS_DEFAULT = 16;

  // Width of a slot's period and counter
  localparam int CNT_W = 11;

  // One tick lasts this many milliseconds
  localparam int MS_PER_TICK = 50;

  // Divide by 50 as (ms * DIV_MUL) >> DIV_SHIFT, exact for any 16-bit ms
  localparam int MS_W      = 16;
  localparam int DIV_MUL_W = 17;
  localparam int DIV_MUL   = 83887;
  localparam int DIV_SHIFT = 22;
  localparam int PROD_W    = MS_W + DIV_MUL_W;

  // Counter value after a slot fires
  localparam logic [CNT_W-1:0] COUNT_AFTER_FIRE = CNT_W'(1);

  // Result codes
  typedef enum logic [2:0] {
    KIND_REGISTERED = 3'd0,
    KIND_FULL       = 3'd1,
    KIND_SHORT      = 3'd2,
    KIND_FIRED      = 3'd3,
    KIND_IDLE       = 3'd4
  } kind_t;

  // Request codes
  localparam logic REQ_REGISTER = 1'b0;
  localparam logic REQ_TICK     = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REG_SCAN,
    ST_TICK_PRIME,
    ST_TICK_WALK,
    ST_FLUSH
  } state_t;

  // Input item
  typedef struct packed {
    logic            req_type;
    logic [7:0]      client_id;
    logic [MS_W-1:0] period_ms;
  } req_t;

  // Result item
  typedef struct packed {
    kind_t      result_kind;
    logic [3:0] slot_index;
    logic [7:0] fired_client;
    logic       last;
  } rsp_t;

endpackage

`default_nettype wire

@@ src/periodic_callback_slot_scheduler.sv @@
// Periodic callback slot scheduler: table of timer slots walked by one sequencer.
// Depends on pcss_pkg for payload structs, result codes and states.
`timescale 1ns / 1ps
`default_nettype none

// A register item takes the lowest free slot and stores its client and a period
// of period_ms / 50 ticks; intervals of 50 ms or less, and a full table, are
// rejected with their own result. A tick item walks every slot in ascending
// order, one slot per cycle through the single read port of the slot table
// while no second report waits on a full result register, and reports each
// slot whose counter has reached its period, the last report marked with last;
// a tick with nothing due gives one idle result. The block takes one item at a
// time: the free-slot scan of a register item visits one slot per cycle, and
// either kind of item also waits while the result side holds off ready.
// After reset the table is empty and the block is ready at once.
module periodic_callback_slot_scheduler #(
  parameter int SLOTS = pcss_pkg::SLOTS_DEFAULT
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  output      logic            req_ready,
  input  wire pcss_pkg::req_t  req,
  output      logic            rsp_valid,
  input  wire logic            rsp_ready,
  output      pcss_pkg::rsp_t  rsp
);

  localparam int IDXW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = pcss_pkg::CNT_W;

  // Low four bits of a slot number, as the result field carries it
  function automatic logic [3:0] slot_num(input logic [IDXW-1:0] i);
    logic [IDXW+3:0] w;
    w = {4'b0000, i};
    return w[3:0];
  endfunction

  pcss_pkg::state_t state, state_next;

  // Slot table: valid bits in flops, the rest in memory
  logic [SLOTS-1:0] slot_used;
  logic [7:0]       slot_client [SLOTS];
  logic [CNT_W-1:0] slot_period [SLOTS];
  logic [CNT_W-1:0] slot_count  [SLOTS];

  logic [7:0]       rd_client;
  logic [CNT_W-1:0] rd_period;
  logic [CNT_W-1:0] rd_count;

  logic [IDXW-1:0]  idx;
  logic [IDXW-1:0]  cur;
  logic [7:0]       client;
  logic [CNT_W-1:0] period;
  pcss_pkg::rsp_t   pend;
  logic             pend_valid;

  logic [pcss_pkg::PROD_W-1:0] prod;
  logic accept, is_short, idx_last, cur_last, out_free, fire;
  logic scan_take, scan_full, walk_adv, walk_emit, flush_emit, rd_en;
  logic cnt_we;
  logic [IDXW-1:0]  cnt_addr;
  logic [CNT_W-1:0] cnt_wdata;

  // Shared datapath terms
  assign prod = pcss_pkg::PROD_W'(req.period_ms)
              * pcss_pkg::PROD_W'(pcss_pkg::DIV_MUL);
  assign is_short = (req.period_ms <= pcss_pkg::MS_W'(pcss_pkg::MS_PER_TICK));
  assign idx_last = (idx == IDXW'(SLOTS - 1));
  assign cur_last = (cur == IDXW'(SLOTS - 1));
  assign out_free = !rsp_valid || rsp_ready;
  assign fire     = slot_used[cur] && (rd_count == rd_period);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      pcss_pkg::ST_IDLE: begin
        if (req_valid) begin
          if (req.req_type == pcss_pkg::REQ_TICK) begin
            state_next = pcss_pkg::ST_TICK_PRIME;
          end else if (is_short) begin
            state_next = pcss_pkg::ST_FLUSH;
          end else begin
            state_next = pcss_pkg::ST_REG_SCAN;
          end
        end
      end
      pcss_pkg::ST_REG_SCAN: begin
        if (!slot_used[idx] || idx_last) begin
          state_next = pcss_pkg::ST_FLUSH;
        end
      end
      pcss_pkg::ST_TICK_PRIME: state_next = pcss_pkg::ST_TICK_WALK;
      pcss_pkg::ST_TICK_WALK: begin
        if (walk_adv && cur_last) begin
          state_next = pcss_pkg::ST_FLUSH;
        end
      end
      pcss_pkg::ST_FLUSH: begin
        if (out_free) begin
          state_next = pcss_pkg::ST_IDLE;
        end
      end
      default: state_next = pcss_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    req_ready  = 1'b0;
    scan_take  = 1'b0;
    scan_full  = 1'b0;
    walk_adv   = 1'b0;
    walk_emit  = 1'b0;
    flush_emit = 1'b0;
    rd_en      = 1'b0;
    case (state)
      pcss_pkg::ST_IDLE: req_ready = 1'b1;
      pcss_pkg::ST_REG_SCAN: begin
        scan_take = !slot_used[idx];
        scan_full = slot_used[idx] && idx_last;
      end
      pcss_pkg::ST_TICK_PRIME: rd_en = 1'b1;
      pcss_pkg::ST_TICK_WALK: begin
        // Stall only when a second report is due and the output is still full
        walk_adv  = !(fire && pend_valid && !out_free);
        walk_emit = walk_adv && fire && pend_valid;
        rd_en     = walk_adv;
      end
      pcss_pkg::ST_FLUSH: flush_emit = out_free;
      default: req_ready = 1'b0;
    endcase
  end

  assign accept = req_valid && req_ready;

  // Counter write port: clear on register, reload or advance on tick
  always_comb begin
    cnt_we    = 1'b0;
    cnt_addr  = idx;
    cnt_wdata = '0;
    if (scan_take) begin
      cnt_we = 1'b1;
    end else if (walk_adv && slot_used[cur]) begin
      cnt_we    = 1'b1;
      cnt_addr  = cur;
      cnt_wdata = fire ? pcss_pkg::COUNT_AFTER_FIRE : rd_count + CNT_W'(1);
    end
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pcss_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Slot valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_used <= '0;
    end else if (scan_take) begin
      slot_used[idx] <= 1'b1;
    end
  end

  // Slot table memory, read registered at idx
  always_ff @(posedge clk) begin
    if (scan_take) begin
      slot_client[idx] <= client;
      slot_period[idx] <= period;
    end
    if (cnt_we) begin
      slot_count[cnt_addr] <= cnt_wdata;
    end
    if (rd_en) begin
      rd_client <= slot_client[idx];
      rd_period <= slot_period[idx];
      rd_count  <= slot_count[idx];
    end
  end

  // Latch the request, divide the interval, advance the slot pointers
  always_ff @(posedge clk) begin
    if (accept) begin
      client <= req.client_id;
      period <= prod[pcss_pkg::DIV_SHIFT +: CNT_W];
      idx    <= '0;
    end else if (state == pcss_pkg::ST_REG_SCAN && !scan_take && !idx_last) begin
      idx <= idx + IDXW'(1);
    end else if (rd_en) begin
      cur <= idx;
      if (!idx_last) begin
        idx <= idx + IDXW'(1);
      end
    end
  end

  // Pending result: held until the next report or the end of the item
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (accept) begin
      pend_valid <= (req.req_type == pcss_pkg::REQ_REGISTER) && is_short;
    end else if (scan_take || scan_full || (walk_adv && fire)) begin
      pend_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend <= '{result_kind: pcss_pkg::KIND_SHORT, slot_index: 4'd0,
                fired_client: 8'd0, last: 1'b0};
    end else if (scan_take) begin
      pend <= '{result_kind: pcss_pkg::KIND_REGISTERED, slot_index: slot_num(idx),
                fired_client: 8'd0, last: 1'b0};
    end else if (scan_full) begin
      pend <= '{result_kind: pcss_pkg::KIND_FULL, slot_index: 4'd0,
                fired_client: 8'd0, last: 1'b0};
    end else if (walk_adv && fire) begin
      pend <= '{result_kind: pcss_pkg::KIND_FIRED, slot_index: slot_num(cur),
                fired_client: rd_client, last: 1'b0};
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (walk_emit || flush_emit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (walk_emit) begin
      rsp <= pend;
    end else if (flush_emit) begin
      if (pend_valid) begin
        rsp <= '{result_kind: pend.result_kind, slot_index: pend.slot_index,
                 fired_client: pend.fired_client, last: 1'b1};
      end else begin
        rsp <= '{result_kind: pcss_pkg::KIND_IDLE, slot_index: 4'd0,
                 fired_client: 8'd0, last: 1'b1};
      end
    end
  end

endmodule

`default_nettype wire

@@ src/pcss_checker.sv @@
// Port-level checker for the periodic callback slot scheduler, with its bind.
// Depends on pcss_pkg and on the ports of periodic_callback_slot_scheduler.
`timescale 1ns / 1ps
`default_nettype none

module pcss_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           req_valid,
  input wire logic           req_ready,
  input wire pcss_pkg::req_t req,
  input wire logic           rsp_valid,
  input wire logic           rsp_ready,
  input wire pcss_pkg::rsp_t rsp
);

  // Hold a stalled result
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  // One item at a time: drop ready after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("ready held after an accept");

  // Only a fired report can be followed by more results of the same item
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.result_kind != pcss_pkg::KIND_FIRED |-> rsp.last)
    else $error("non-fired result without last");

  // Client field is zero except on a fired report
  a_client_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.result_kind != pcss_pkg::KIND_FIRED |-> rsp.fired_client == 8'd0)
    else $error("client set on a non-fired result");

  // No item is taken while a result of the previous one is still pending
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.last |-> !req_ready)
    else $error("ready while an item is unfinished");

endmodule

bind periodic_callback_slot_scheduler pcss_checker u_pcss_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

`default_nettype wire
